// ===== hw/rtl/ntpcal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpcal_pkg
// Shared types and constants for the NTP seconds to BCD calendar unit.
// ----------------------------------------------------------------------------
package ntpcal_pkg;

	localparam logic [31:0] EPOCH_GAP    = 32'd2208988800;
	localparam logic [31:0] DAY_SECONDS  = 32'd86400;
	localparam logic [31:0] HOUR_SECONDS = 32'd3600;
	localparam logic [31:0] MIN_SECONDS  = 32'd60;
	localparam logic [31:0] WEEK_DAYS    = 32'd7;
	localparam logic [6:0]  Y2K_OFFSET   = 7'd30;
	localparam logic [3:0]  LAST_MONTH   = 4'd12;

	typedef logic [3:0] step_t;

	typedef enum logic [2:0] {
		SEL_GAP,
		SEL_DAY,
		SEL_HOUR,
		SEL_MIN,
		SEL_WEEK,
		SEL_YEAR,
		SEL_Y2K,
		SEL_MONTH
	} sel_t;

	typedef enum logic [2:0] {
		X_NONE,
		X_DAYS,
		X_HOURS,
		X_MIN,
		X_WD,
		X_MON,
		X_EMIT
	} xfer_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_KLOOP,
		J_FIT,
		J_NOFIT,
		J_DONE
	} jmp_t;

	typedef struct packed {
		sel_t       sel;
		logic       sub_en;
		logic       set_oor;
		logic       k_dec;
		logic       k_ld;
		logic [3:0] k_val;
		xfer_t      xfer;
		jmp_t       jmp;
		step_t      target;
	} ctrl_t;

	typedef struct packed {
		logic fit;
		logic k_zero;
	} stat_t;

	localparam ctrl_t CTRL_NOP = '{
		sel: SEL_GAP, sub_en: 1'b0, set_oor: 1'b0, k_dec: 1'b0, k_ld: 1'b0,
		k_val: 4'd0, xfer: X_NONE, jmp: J_DONE, target: 4'd0
	};

	function automatic logic [7:0] bin2bcd(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  o;
		p = 15'(v) * 15'd205;
		t = p[14:11];
		o = v - 7'(t) * 7'd10;
		return {t, o[3:0]};
	endfunction

endpackage

// ===== hw/rtl/ntpcal_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpcal_useq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module ntpcal_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ntpcal_pkg::stat_t  stat,
	output logic               busy,
	output logic               load,
	output ntpcal_pkg::ctrl_t  ctrl
);
	import ntpcal_pkg::*;

	localparam step_t ST_GAP   = 4'd0;
	localparam step_t ST_DAY   = 4'd1;
	localparam step_t ST_XDAY  = 4'd2;
	localparam step_t ST_HOUR  = 4'd3;
	localparam step_t ST_XHOUR = 4'd4;
	localparam step_t ST_MIN   = 4'd5;
	localparam step_t ST_XMIN  = 4'd6;
	localparam step_t ST_WEEK  = 4'd7;
	localparam step_t ST_XWD   = 4'd8;
	localparam step_t ST_YEAR  = 4'd9;
	localparam step_t ST_Y2K   = 4'd10;
	localparam step_t ST_MONTH = 4'd11;
	localparam step_t ST_EMIT  = 4'd12;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = CTRL_NOP;
		case (s)
			ST_GAP: begin
				c.sel = SEL_GAP; c.sub_en = 1'b1; c.set_oor = 1'b1;
				c.k_ld = 1'b1; c.k_val = 4'd14;
				c.jmp = J_NOFIT; c.target = ST_EMIT;
			end
			ST_DAY: begin
				c.sel = SEL_DAY; c.sub_en = 1'b1; c.k_dec = 1'b1; c.jmp = J_KLOOP;
			end
			ST_XDAY: begin
				c.xfer = X_DAYS; c.k_ld = 1'b1; c.k_val = 4'd4; c.jmp = J_NEXT;
			end
			ST_HOUR: begin
				c.sel = SEL_HOUR; c.sub_en = 1'b1; c.k_dec = 1'b1; c.jmp = J_KLOOP;
			end
			ST_XHOUR: begin
				c.xfer = X_HOURS; c.k_ld = 1'b1; c.k_val = 4'd5; c.jmp = J_NEXT;
			end
			ST_MIN: begin
				c.sel = SEL_MIN; c.sub_en = 1'b1; c.k_dec = 1'b1; c.jmp = J_KLOOP;
			end
			ST_XMIN: begin
				c.xfer = X_MIN; c.k_ld = 1'b1; c.k_val = 4'd12; c.jmp = J_NEXT;
			end
			ST_WEEK: begin
				c.sel = SEL_WEEK; c.sub_en = 1'b1; c.k_dec = 1'b1; c.jmp = J_KLOOP;
			end
			ST_XWD: begin
				c.xfer = X_WD; c.jmp = J_NEXT;
			end
			ST_YEAR: begin
				c.sel = SEL_YEAR; c.sub_en = 1'b1; c.jmp = J_FIT;
			end
			ST_Y2K: begin
				c.sel = SEL_Y2K; c.set_oor = 1'b1; c.xfer = X_MON;
				c.jmp = J_NOFIT; c.target = ST_EMIT;
			end
			ST_MONTH: begin
				c.sel = SEL_MONTH; c.sub_en = 1'b1; c.jmp = J_FIT;
			end
			ST_EMIT: begin
				c.xfer = X_EMIT; c.jmp = J_DONE;
			end
			default: c = CTRL_NOP;
		endcase
		return c;
	endfunction

	logic  run_q;
	step_t step_q;
	ctrl_t word;

	assign word = ucode(step_q);
	assign ctrl = run_q ? word : CTRL_NOP;
	assign busy = run_q;
	assign load = start && !run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= ST_GAP;
		end else if (load) begin
			run_q  <= 1'b1;
			step_q <= ST_GAP;
		end else if (run_q) begin
			case (word.jmp)
				J_NEXT:  step_q <= step_q + 4'd1;
				J_KLOOP: if (stat.k_zero) step_q <= step_q + 4'd1;
				J_FIT:   if (!stat.fit) step_q <= step_q + 4'd1;
				J_NOFIT: step_q <= stat.fit ? step_q + 4'd1 : word.target;
				J_DONE:  run_q <= 1'b0;
				default: run_q <= 1'b0;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ntpcal_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpcal_dpath
// Datapath: one compare-and-subtract unit, working registers, result registers.
// ----------------------------------------------------------------------------
module ntpcal_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [31:0]        ntp_seconds,
	input  ntpcal_pkg::ctrl_t  ctrl,
	output ntpcal_pkg::stat_t  stat,
	output logic               done,
	output logic [6:0]         seconds_bcd,
	output logic [6:0]         minutes_bcd,
	output logic [5:0]         hours_bcd,
	output logic [2:0]         weekday,
	output logic [5:0]         date_bcd,
	output logic [4:0]         month_bcd,
	output logic [7:0]         year_bcd,
	output logic               out_of_range
);
	import ntpcal_pkg::*;

	logic [31:0] r_q;
	logic [14:0] q_q;
	logic [3:0]  k_q;
	logic [14:0] days_q;
	logic [4:0]  hh_q;
	logic [5:0]  mm_q;
	logic [5:0]  ss_q;
	logic [2:0]  wd_q;
	logic [6:0]  yr_q;
	logic [3:0]  mon_q;
	logic        oor_q;
	logic        done_q;

	logic [6:0]  sec_q, min_q;
	logic [5:0]  hour_q, date_q;
	logic [2:0]  wday_q;
	logic [4:0]  month_q;
	logic [7:0]  year_q;
	logic        oor_out_q;

	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic [31:0] operand;
	logic [31:0] diff;
	logic        fit;
	logic        is_div;
	logic [7:0]  bcd_ss, bcd_mm, bcd_hh, bcd_dd, bcd_mo, bcd_yy;

	always_comb begin
		leap = (yr_q[1:0] == 2'd2);
		ylen = leap ? 9'd366 : 9'd365;
		if (mon_q == 4'd2) begin
			mlen = leap ? 5'd29 : 5'd28;
		end else if (mon_q inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			mlen = 5'd30;
		end else begin
			mlen = 5'd31;
		end
	end

	always_comb begin
		case (ctrl.sel)
			SEL_GAP:   operand = EPOCH_GAP;
			SEL_DAY:   operand = DAY_SECONDS << k_q;
			SEL_HOUR:  operand = HOUR_SECONDS << k_q;
			SEL_MIN:   operand = MIN_SECONDS << k_q;
			SEL_WEEK:  operand = WEEK_DAYS << k_q;
			SEL_YEAR:  operand = 32'(ylen);
			SEL_MONTH: operand = 32'(mlen);
			default:   operand = '0;
		endcase
		diff   = r_q - operand;
		is_div = ctrl.sel inside {SEL_DAY, SEL_HOUR, SEL_MIN, SEL_WEEK};
		case (ctrl.sel)
			SEL_Y2K:   fit = (yr_q >= Y2K_OFFSET);
			SEL_MONTH: fit = (mon_q != LAST_MONTH) && (r_q >= operand);
			default:   fit = (r_q >= operand);
		endcase
	end

	assign stat.fit    = fit;
	assign stat.k_zero = (k_q == 4'd0);

	always_comb begin
		bcd_ss = bin2bcd({1'b0, ss_q});
		bcd_mm = bin2bcd({1'b0, mm_q});
		bcd_hh = bin2bcd({2'b0, hh_q});
		bcd_dd = bin2bcd(7'(r_q[4:0]) + 7'd1);
		bcd_mo = bin2bcd({3'b0, mon_q});
		bcd_yy = bin2bcd(yr_q - Y2K_OFFSET);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			k_q    <= '0;
			oor_q  <= 1'b0;
		end else if (load) begin
			done_q <= 1'b0;
			k_q    <= '0;
			oor_q  <= 1'b0;
		end else begin
			done_q <= (ctrl.xfer == X_EMIT);
			if (ctrl.k_ld) begin
				k_q <= ctrl.k_val;
			end else if (ctrl.k_dec) begin
				k_q <= k_q - 4'd1;
			end
			if (ctrl.set_oor && !fit) begin
				oor_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r_q <= ntp_seconds;
			q_q <= '0;
		end else begin
			if (ctrl.sub_en && fit) begin
				r_q <= diff;
				if (is_div) begin
					q_q[k_q] <= 1'b1;
				end
				if (ctrl.sel == SEL_YEAR) begin
					yr_q <= yr_q + 7'd1;
				end
				if (ctrl.sel == SEL_MONTH) begin
					mon_q <= mon_q + 4'd1;
				end
			end
			case (ctrl.xfer)
				X_NONE: begin
				end
				X_DAYS: begin
					days_q <= q_q;
					q_q    <= '0;
				end
				X_HOURS: begin
					hh_q <= q_q[4:0];
					q_q  <= '0;
				end
				X_MIN: begin
					mm_q <= q_q[5:0];
					ss_q <= r_q[5:0];
					q_q  <= '0;
					r_q  <= {16'b0, {1'b0, days_q} + 16'd3};
				end
				X_WD: begin
					wd_q <= r_q[2:0] + 3'd1;
					q_q  <= '0;
					r_q  <= {17'b0, days_q};
					yr_q <= '0;
				end
				X_MON: begin
					mon_q <= 4'd1;
				end
				X_EMIT: begin
					oor_out_q <= oor_q;
					if (oor_q) begin
						sec_q   <= '0;
						min_q   <= '0;
						hour_q  <= '0;
						wday_q  <= '0;
						date_q  <= '0;
						month_q <= '0;
						year_q  <= '0;
					end else begin
						sec_q   <= bcd_ss[6:0];
						min_q   <= bcd_mm[6:0];
						hour_q  <= bcd_hh[5:0];
						wday_q  <= wd_q;
						date_q  <= bcd_dd[5:0];
						month_q <= bcd_mo[4:0];
						year_q  <= bcd_yy;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done         = done_q;
	assign seconds_bcd  = sec_q;
	assign minutes_bcd  = min_q;
	assign hours_bcd    = hour_q;
	assign weekday      = wday_q;
	assign date_bcd     = date_q;
	assign month_bcd    = month_q;
	assign year_bcd     = year_q;
	assign out_of_range = oor_out_q;

endmodule

// ===== hw/rtl/ntp_seconds_to_bcd_calendar_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_seconds_to_bcd_calendar_unit
// NTP era-zero seconds to packed BCD calendar fields and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive ntp_seconds and raise start; the transfer happens on a
//   rising edge with start high and busy low. busy stays high while the
//   microcode runs.
//   Output: done is high for exactly one cycle with all result fields
//   valid; the receiver takes the transfer in that cycle and cannot stall.
//   Timing: the time from the start transfer to the done strobe grows
//   with Y (0 to 66), the number of whole years walked from 1970, and M
//   (0 to 11), the number of whole months walked; both walks run through
//   the single compare-and-subtract unit. Times before 1970 go straight
//   to the done strobe after the epoch step, and other times before 2000
//   go to it after the year walk, skipping the month walk.
//   Throughput: one conversion at a time; start is taken again in the
//   cycle done is high.
//   Reset: arst_n clears the sequencer and the done strobe; the block is
//   then idle and ready.
// ----------------------------------------------------------------------------
module ntp_seconds_to_bcd_calendar_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] ntp_seconds,
	output logic        done,
	output logic [6:0]  seconds_bcd,
	output logic [6:0]  minutes_bcd,
	output logic [5:0]  hours_bcd,
	output logic [2:0]  weekday,
	output logic [5:0]  date_bcd,
	output logic [4:0]  month_bcd,
	output logic [7:0]  year_bcd,
	output logic        out_of_range
);
	import ntpcal_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic  load;

	ntpcal_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.load   (load),
		.ctrl   (ctrl)
	);

	ntpcal_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.ntp_seconds  (ntp_seconds),
		.ctrl         (ctrl),
		.stat         (stat),
		.done         (done),
		.seconds_bcd  (seconds_bcd),
		.minutes_bcd  (minutes_bcd),
		.hours_bcd    (hours_bcd),
		.weekday      (weekday),
		.date_bcd     (date_bcd),
		.month_bcd    (month_bcd),
		.year_bcd     (year_bcd),
		.out_of_range (out_of_range)
	);

endmodule

// ===== hw/rtl/ntpcal_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpcal_chk
// Port-level checks for the calendar unit, bound to the top level.
// ----------------------------------------------------------------------------
module ntpcal_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [6:0]  seconds_bcd,
	input logic [6:0]  minutes_bcd,
	input logic [5:0]  hours_bcd,
	input logic [2:0]  weekday,
	input logic [5:0]  date_bcd,
	input logic [4:0]  month_bcd,
	input logic [7:0]  year_bcd,
	input logic        out_of_range
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer accepted without busy rising");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still converting");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> seconds_bcd == 7'd0 && minutes_bcd == 7'd0 &&
			hours_bcd == 6'd0 && weekday == 3'd0 && date_bcd == 6'd0 &&
			month_bcd == 5'd0 && year_bcd == 8'd0)
		else $error("out-of-range result carries non-zero fields");

	a_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range |-> weekday != 3'd0 && month_bcd != 5'd0 &&
			date_bcd != 6'd0)
		else $error("in-range result with empty weekday, month or date");

endmodule

bind ntp_seconds_to_bcd_calendar_unit ntpcal_chk u_chk (.*);
